/* src/ibc_pkg.sv */
// ----------------------------------------------------------------------------
// ibc_pkg - shared types and constants for the IMU bias calibration block
// Axis codes, payload structs, offset-write interface and reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ibc_pkg;

    localparam int CAL_SAMPLES = 1000;
    localparam int AXES        = 6;
    localparam int AXIS_W      = 3;
    localparam int DATA_W      = 16;
    localparam int GRAV_W      = 15;
    localparam int SUM_W       = 26;
    localparam int MAG_W       = SUM_W - 1;
    localparam int COUNT_W     = $clog2(CAL_SAMPLES + 1);

    // Exact floor division by CAL_SAMPLES for magnitudes below 2^MAG_W:
    // q = (mag * RECIP) >> RECIP_SHIFT, RECIP = ceil(2^RECIP_SHIFT / CAL_SAMPLES).
    localparam int CAL_LOG2    = $clog2(CAL_SAMPLES);
    localparam int RECIP_SHIFT = MAG_W + CAL_LOG2;
    localparam int RECIP_W     = MAG_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int PROD_W      = MAG_W + RECIP_W;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd16384;

    typedef logic [AXIS_W-1:0] axis_t;

    localparam axis_t AXIS_ACCEL_X = 3'd0;
    localparam axis_t AXIS_ACCEL_Y = 3'd1;
    localparam axis_t AXIS_ACCEL_Z = 3'd2;
    localparam axis_t AXIS_GYRO_X  = 3'd3;
    localparam axis_t AXIS_GYRO_Y  = 3'd4;
    localparam axis_t AXIS_GYRO_Z  = 3'd5;
    localparam axis_t AXIS_LAST    = AXIS_GYRO_Z;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_z;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cal_accel_x;
        logic signed [DATA_W-1:0] cal_accel_y;
        logic signed [DATA_W-1:0] cal_accel_z;
        logic signed [DATA_W-1:0] cal_gyro_x;
        logic signed [DATA_W-1:0] cal_gyro_y;
        logic signed [DATA_W-1:0] cal_gyro_z;
    } result_t;

    // Finished sum headed for the offset divider
    typedef struct packed {
        logic                    valid;
        axis_t                   axis;
        logic signed [SUM_W-1:0] sum;
    } div_req_t;

    // Offset memory write from the divider
    typedef struct packed {
        logic              en;
        axis_t             addr;
        logic [DATA_W-1:0] data;
    } off_wr_t;

    function automatic logic [DATA_W-1:0] axis_value(sample_t s, axis_t a);
        logic [DATA_W-1:0] v;
        case (a)
            AXIS_ACCEL_X: v = s.accel_x;
            AXIS_ACCEL_Y: v = s.accel_y;
            AXIS_ACCEL_Z: v = s.accel_z;
            AXIS_GYRO_X:  v = s.gyro_x;
            AXIS_GYRO_Y:  v = s.gyro_y;
            AXIS_GYRO_Z:  v = s.gyro_z;
            default:      v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/ibc_offset_div.sv */
// ----------------------------------------------------------------------------
// ibc_offset_div - sum to offset conversion
// Divides a finished axis sum by the sample count (truncating toward zero)
// by reciprocal multiply, removes gravity from accel Z, emits an offset write.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_offset_div
    import ibc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_req_t          req,
    input  wire logic [GRAV_W-1:0] gravity,
    output off_wr_t                wr
);

    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg;
    logic              mag_valid_reg;
    axis_t             mag_axis_reg;

    logic [PROD_W-1:0] prod_reg;
    logic              prod_neg_reg;
    logic              prod_valid_reg;
    axis_t             prod_axis_reg;

    logic [SUM_W-1:0]  abs_sum;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] signed_quot;
    logic [DATA_W-1:0] offset;

    assign abs_sum = req.sum[SUM_W-1] ? -req.sum : req.sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            mag_valid_reg  <= req.valid;
            prod_valid_reg <= mag_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= abs_sum[MAG_W-1:0];
        neg_reg       <= req.sum[SUM_W-1];
        mag_axis_reg  <= req.axis;
        prod_reg      <= PROD_W'(mag_reg) * PROD_W'(RECIP);
        prod_neg_reg  <= neg_reg;
        prod_axis_reg <= mag_axis_reg;
    end

    always_comb
    begin
        quot        = prod_reg[RECIP_SHIFT +: DATA_W];
        signed_quot = prod_neg_reg ? -quot : quot;
        if (prod_axis_reg == AXIS_ACCEL_Z)
            offset = signed_quot - {1'b0, gravity};
        else
            offset = signed_quot;
    end

    assign wr.en   = prod_valid_reg;
    assign wr.addr = prod_axis_reg;
    assign wr.data = offset;

endmodule

`default_nettype wire

/* src/imu_bias_calibration_top.sv */
// ----------------------------------------------------------------------------
// imu_bias_calibration_top - IMU bias calibration by averaging
// Sums the first CAL_SAMPLES six-axis samples per axis, turns the sums into
// offsets, then returns every later sample minus its per-axis offset.
// ----------------------------------------------------------------------------
//
//  channel  | signals                     | direction | transaction
//  ---------+-----------------------------+-----------+----------------------------
//  sample   | sample_valid/stall, sample  | in        | valid & !stall
//  result   | result_valid/stall, result  | out       | valid & !stall
//  cfg      | cfg_valid/ready, cfg_data   | in        | valid & ready (gravity)
//
//  One axis per cycle: a sample holds the issue stage until its last axis issues,
//  bound by the single read port of the sums/offsets memories; the next sample can
//  be taken on the cycle the previous one issues its last axis.
//  Accept to result_valid: item, stage-1, assembly and output registers in order.
//  Reset needs no clearing pass; the first calibration sample ignores the sums read.
//  A stalled result parks in the output register, a second in the assembly
//  buffer; sample_stall rises mid-issue or with two in flight. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bias_calibration_top
    import ibc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire sample_t           sample,

    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [GRAV_W-1:0] cfg_data
);

    // ---------------- configuration ----------------
    logic [GRAV_W-1:0] gravity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gravity_reg <= GRAVITY_RESET;
        else if (cfg_valid && cfg_ready)
            gravity_reg <= cfg_data;
    end

    // ---------------- calibration progress ----------------
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               calibrated_reg, calibrated_next;
    logic [COUNT_W-1:0] count_inc;
    logic               accept;
    logic               last_cal;

    // ---------------- issue stage ----------------
    logic    busy_reg, busy_next;
    axis_t   axis_cnt_reg, axis_cnt_next;
    sample_t item_reg;
    logic    item_cal_reg;      // calibration sample: accumulate only
    logic    item_first_reg;    // first sample since reset: sums read as zero
    logic    item_final_reg;    // last calibration sample: compute offsets
    logic    last_axis;

    // results in flight from accept to delivery (output + assembly = 2)
    logic [1:0] in_flight_reg, in_flight_next;
    logic       deliver;

    assign count_inc = count_reg + COUNT_W'(1);
    assign last_cal  = (count_inc >= COUNT_W'(CAL_SAMPLES));
    assign last_axis = (axis_cnt_reg == AXIS_LAST);
    assign sample_stall = !((!busy_reg || last_axis) && (in_flight_reg < 2'd2));
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        count_next      = count_reg;
        calibrated_next = calibrated_reg;
        if (accept && !calibrated_reg)
        begin
            count_next = count_inc;
            if (last_cal)
                calibrated_next = 1'b1;
        end
    end

    always_comb
    begin
        busy_next     = busy_reg;
        axis_cnt_next = axis_cnt_reg;
        if (accept)
        begin
            busy_next     = 1'b1;
            axis_cnt_next = AXIS_ACCEL_X;
        end
        else if (busy_reg)
        begin
            if (last_axis)
                busy_next = 1'b0;
            else
                axis_cnt_next = axis_cnt_reg + AXIS_W'(1);
        end
    end

    always_comb
    begin
        in_flight_next = in_flight_reg;
        if (accept && calibrated_reg && !deliver)
            in_flight_next = in_flight_reg + 2'd1;
        else if (deliver && !(accept && calibrated_reg))
            in_flight_next = in_flight_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            calibrated_reg <= 1'b0;
            busy_reg       <= 1'b0;
            axis_cnt_reg   <= AXIS_ACCEL_X;
            in_flight_reg  <= 2'd0;
        end
        else
        begin
            count_reg      <= count_next;
            calibrated_reg <= calibrated_next;
            busy_reg       <= busy_next;
            axis_cnt_reg   <= axis_cnt_next;
            in_flight_reg  <= in_flight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg       <= sample;
            item_cal_reg   <= !calibrated_reg;
            item_first_reg <= (count_reg == '0);
            item_final_reg <= !calibrated_reg && last_cal;
        end
    end

    // ---------------- state memories ----------------
    // Per-axis running sums and offsets, one read per cycle at the issue axis.
    logic signed [SUM_W-1:0] sum_mem [AXES];
    logic [DATA_W-1:0]       off_mem [AXES];
    logic signed [SUM_W-1:0] sum_rd_reg;
    logic [DATA_W-1:0]       off_rd_reg;

    // stage 1 (read data back) control
    logic              p1_valid_reg;
    axis_t             p1_axis_reg;
    logic [DATA_W-1:0] p1_sample_reg;
    logic              p1_cal_reg;
    logic              p1_first_reg;
    logic              p1_final_reg;

    logic signed [SUM_W-1:0] sum_base;
    logic signed [SUM_W-1:0] sum_new;
    logic                    sum_we;
    logic [DATA_W-1:0]       diff;
    div_req_t                div_req;
    off_wr_t                 off_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= busy_reg;
    end

    always_ff @(posedge clk)
    begin
        p1_axis_reg   <= axis_cnt_reg;
        p1_sample_reg <= axis_value(item_reg, axis_cnt_reg);
        p1_cal_reg    <= item_cal_reg;
        p1_first_reg  <= item_first_reg;
        p1_final_reg  <= item_final_reg;
    end

    // read-modify-write: the same axis of the next sample is read only after the
    // previous sample issues every axis, after both write-backs land, so no forwarding path is needed
    always_ff @(posedge clk)
    begin
        sum_rd_reg <= sum_mem[axis_cnt_reg];
        off_rd_reg <= off_mem[axis_cnt_reg];
        if (sum_we)
            sum_mem[p1_axis_reg] <= sum_new;
        if (off_wr.en)
            off_mem[off_wr.addr] <= off_wr.data;
    end

    always_comb
    begin
        sum_base = p1_first_reg ? '0 : sum_rd_reg;
        sum_new  = sum_base + {{(SUM_W-DATA_W){p1_sample_reg[DATA_W-1]}}, p1_sample_reg};
        sum_we   = p1_valid_reg && p1_cal_reg;
        diff     = p1_sample_reg - off_rd_reg;
    end

    assign div_req.valid = sum_we && p1_final_reg;
    assign div_req.axis  = p1_axis_reg;
    assign div_req.sum   = sum_new;

    ibc_offset_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .gravity (gravity_reg),
        .wr      (off_wr)
    );

    // ---------------- result assembly and output ----------------
    logic [DATA_W-1:0] asm_reg [AXES];
    logic              asm_full_reg, asm_full_next;
    logic              asm_wr;
    logic              asm_done;
    logic              move;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    assign asm_wr   = p1_valid_reg && !p1_cal_reg;
    assign asm_done = asm_wr && (p1_axis_reg == AXIS_LAST);
    assign deliver  = out_valid_reg && !result_stall;
    assign move     = asm_full_reg && (!out_valid_reg || deliver);

    always_comb
    begin
        asm_full_next = asm_full_reg;
        if (asm_done)
            asm_full_next = 1'b1;
        else if (move)
            asm_full_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (deliver)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            asm_full_reg  <= asm_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (asm_wr)
            asm_reg[p1_axis_reg] <= diff;
        if (move)
        begin
            out_reg.cal_accel_x <= asm_reg[AXIS_ACCEL_X];
            out_reg.cal_accel_y <= asm_reg[AXIS_ACCEL_Y];
            out_reg.cal_accel_z <= asm_reg[AXIS_ACCEL_Z];
            out_reg.cal_gyro_x  <= asm_reg[AXIS_GYRO_X];
            out_reg.cal_gyro_y  <= asm_reg[AXIS_GYRO_Y];
            out_reg.cal_gyro_z  <= asm_reg[AXIS_GYRO_Z];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

/* dv/tb_imu_bias_calibration_top.sv */
// ----------------------------------------------------------------------------
// tb_imu_bias_calibration_top - self-checking bench for the IMU bias block
// Feeds one calibration run of CAL_SAMPLES samples (corner rows first, then
// biased random samples under several gravity settings), then random samples
// checked against a local bias predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_imu_bias_calibration_top;
    import ibc_pkg::*;

    localparam int CAL_PHASE   = 300;   // samples per random calibration phase
    localparam int POST_PHASE  = 475;   // samples per phase after calibration
    localparam int SETTLE      = 32;    // quiet cycles before a gravity write
    localparam int HOLD_CYCLES = 150;   // long receiver hold-off
    localparam int HOLD_AT     = 300;   // results seen before the hold-off
    localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles with no transaction
    localparam int MAX_PRINTS  = 40;
    localparam int N_CORNERS   = 18;

    typedef struct {
        sample_t smp;
        bit      gives_result;
    } corner_row_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    sample_t           sample       = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [GRAV_W-1:0] cfg_data     = '0;

    // Set with each directed row: the table says no transaction comes out
    logic              typed_none   = 1'b0;

    imu_bias_calibration_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bias predictor state: running sums, offsets, sample count, gravity
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0]  acc_sum  [AXES];
    logic        [DATA_W-1:0] bias_off [AXES];
    logic        [COUNT_W-1:0] cal_count = '0;
    bit                       cal_done  = 1'b0;
    logic        [GRAV_W-1:0] grav_model = GRAVITY_RESET;

    result_t expected_q [$];
    int      err_count    = 0;
    int      results_seen = 0;
    int      idle_cycles  = 0;
    int      burst_left   = 0;
    logic [DATA_W-1:0] axis_base [AXES];

    string field_names [AXES] = '{"cal_accel_x", "cal_accel_y", "cal_accel_z",
                                  "cal_gyro_x", "cal_gyro_y", "cal_gyro_z"};

    // Directed rows: all fall in calibration, so none yields a transaction.
    corner_row_t corner_rows [N_CORNERS] = '{
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0},
        '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0},
        '{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0},
        '{'{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0},
        '{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b0},
        '{'{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001}, 1'b0},
        '{'{16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555}, 1'b0},
        '{'{16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA}, 1'b0},
        '{'{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0},
        '{'{16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'shC000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0},
        '{'{16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF}, 1'b0}
    };

    // Calibrating: accumulate, and on the last sample turn sums into offsets
    // (truncated toward zero) with gravity taken off Z. Calibrated: subtract.
    function automatic void calibrate_or_correct(input sample_t s, output bit has_out,
                                                 output result_t r);
        logic signed [DATA_W-1:0] ax  [AXES];
        logic        [DATA_W-1:0] cor [AXES];
        int q;
        ax[AXIS_ACCEL_X] = s.accel_x;
        ax[AXIS_ACCEL_Y] = s.accel_y;
        ax[AXIS_ACCEL_Z] = s.accel_z;
        ax[AXIS_GYRO_X]  = s.gyro_x;
        ax[AXIS_GYRO_Y]  = s.gyro_y;
        ax[AXIS_GYRO_Z]  = s.gyro_z;
        has_out = 1'b0;
        r = '0;
        if (!cal_done)
        begin
            for (int i = 0; i < AXES; i++)
                acc_sum[i] = acc_sum[i] + ax[i];
            cal_count = cal_count + 1'b1;
            if (cal_count >= CAL_SAMPLES)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    q = acc_sum[i];
                    q = q / CAL_SAMPLES;
                    bias_off[i] = q[DATA_W-1:0];
                end
                bias_off[AXIS_ACCEL_Z] = bias_off[AXIS_ACCEL_Z] - DATA_W'(grav_model);
                cal_done = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < AXES; i++)
                cor[i] = ax[i] - bias_off[i];
            r = '{cor[0], cor[1], cor[2], cor[3], cor[4], cor[5]};
            has_out = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Mostly near a per-axis bias, with full-range and extreme values mixed in
    function automatic sample_t draw_sample();
        logic [DATA_W-1:0] v [AXES];
        int pick;
        for (int i = 0; i < AXES; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                v[i] = 16'h8000;
            else if (pick == 1)
                v[i] = 16'h7FFF;
            else if (pick < 5)
                v[i] = DATA_W'($urandom);
            else
                v[i] = axis_base[i] + DATA_W'($urandom_range(0, 511)) - 16'd256;
        end
        return '{v[0], v[1], v[2], v[3], v[4], v[5]};
    endfunction

    // Offer one sample and hold it until the block takes it
    task automatic offer_sample(input sample_t s, input bit none_typed);
        sample       <= s;
        typed_none   <= none_typed;
        sample_valid <= 1'b1;
        do @(posedge clk); while (sample_stall);
    endtask

    // Sender gaps: mostly none or short, a few long, with gap-free bursts
    task automatic idle_gap();
        int gap;
        int r;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                burst_left = $urandom_range(20, 60);
            else if (r < 50)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 95)
                gap = $urandom_range(4, 8);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++)
        begin
            offer_sample(draw_sample(), 1'b0);
            idle_gap();
        end
    endtask

    // Gravity is only written with the block drained and quiet
    task automatic set_gravity(input logic [GRAV_W-1:0] v);
        sample_valid <= 1'b0;
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check each result transaction, predict each sample transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit      has;
        result_t pred;
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", result));
                else
                begin
                    want = expected_q.pop_front();
                    for (int i = 0; i < AXES; i++)
                        if (result[(AXES-1-i)*DATA_W +: DATA_W] !==
                            want[(AXES-1-i)*DATA_W +: DATA_W])
                            report_mismatch($sformatf("result %0d %s: got %h expected %h",
                                results_seen, field_names[i],
                                result[(AXES-1-i)*DATA_W +: DATA_W],
                                want[(AXES-1-i)*DATA_W +: DATA_W]));
                end
            end
            if (sample_valid && !sample_stall)
            begin
                calibrate_or_correct(sample, has, pred);
                if (has && !typed_none)
                    expected_q.push_back(pred);
            end
            if (cfg_valid && cfg_ready)
                grav_model = cfg_data;
        end
    end

    // Watchdog: any transaction on any channel resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("tb_imu_bias_calibration_top: done, errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once results flow so
    // the output and assembly buffers fill and the block stalls its input.
    initial
    begin
        bit held;
        int r;
        int n;
        held = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (!held && results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    result_stall <= 1'b0;
                    n = $urandom_range(1, 24);
                end
                else if (r < 90)
                begin
                    result_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end
                else
                begin
                    result_stall <= 1'b1;
                    n = $urandom_range(10, 50);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [GRAV_W-1:0] last_grav;
        for (int i = 0; i < AXES; i++)
        begin
            acc_sum[i]   = '0;
            bias_off[i]  = '0;
            axis_base[i] = DATA_W'($urandom);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!rst_n);

        // Corner rows under the reset gravity value
        for (int k = 0; k < N_CORNERS; k++)
        begin
            offer_sample(corner_rows[k].smp, !corner_rows[k].gives_result);
            idle_gap();
        end

        // Calibration continues through several gravity settings; only the
        // one held at the last calibration sample reaches the Z offset.
        set_gravity('0);
        run_random(CAL_PHASE);
        set_gravity({GRAV_W{1'b1}});
        run_random(CAL_PHASE);
        set_gravity(GRAV_W'($urandom));
        run_random(CAL_PHASE);
        case ($urandom_range(0, 3))
            0:       last_grav = '0;
            1:       last_grav = {GRAV_W{1'b1}};
            2:       last_grav = GRAVITY_RESET;
            default: last_grav = GRAV_W'($urandom);
        endcase
        set_gravity(last_grav);
        run_random(CAL_SAMPLES - N_CORNERS - 3 * CAL_PHASE);

        // Calibrated: writes are stored but must leave the offsets alone
        set_gravity(GRAV_W'($urandom));
        run_random(POST_PHASE);
        set_gravity({GRAV_W{1'b1}});
        run_random(POST_PHASE);

        sample_valid <= 1'b0;
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("tb_imu_bias_calibration_top: done, clean");
        else
            $display("tb_imu_bias_calibration_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
